/* design/three_axis_running_median_defines.svh */
// assertion macros used by the checker file
`ifndef THREE_AXIS_RUNNING_MEDIAN_DEFINES_SVH
`define THREE_AXIS_RUNNING_MEDIAN_DEFINES_SVH

// same-cycle implication, sampled on clk_i, off while rst_ni is low
`define TARM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("three_axis_running_median: assertion failed");

// next-cycle implication, sampled on clk_i, off while rst_ni is low
`define TARM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("three_axis_running_median: assertion failed");

`endif

/* design/tarm_pkg.sv */
package tarm_pkg;

  // window depth per axis
  localparam int WindowLength = 15;
  localparam int DataW        = 16;
  // age counter width, at least one bit
  localparam int AgeW         = (WindowLength > 1) ? $clog2(WindowLength) : 1;
  localparam int MidIdx       = WindowLength / 2;
  localparam bit EvenWindow   = (WindowLength % 2) == 0;

  typedef logic signed [DataW-1:0] sample_t;
  typedef logic        [AgeW-1:0]  age_t;

  localparam age_t MaxAge = age_t'(WindowLength - 1);

  // what a cell shows its neighbors
  typedef struct packed {
    sample_t value;
    age_t    age;
    logic    le;     // value <= incoming sample
  } cell_link_t;

endpackage

/* design/tarm_if.sv */
// input transaction: one three-axis sample
interface tarm_sample_if;
  import tarm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t sample_x;
  sample_t sample_y;
  sample_t sample_z;

  modport source (output valid, output sample_x, output sample_y, output sample_z,
                  input ready);
  modport sink   (input valid, input sample_x, input sample_y, input sample_z,
                  output ready);
endinterface

// output transaction: one three-axis median
interface tarm_median_if;
  import tarm_pkg::*;

  logic    valid;
  logic    ready;
  sample_t median_x;
  sample_t median_y;
  sample_t median_z;

  modport source (output valid, output median_x, output median_y, output median_z,
                  input ready);
  modport sink   (input valid, input median_x, input median_y, input median_z,
                  output ready);
endinterface

/* design/three_axis_running_median.sv */
// Running median over the last 15 samples of each axis of a three-axis sensor,
// signed 16-bit values, windows starting as all zeros. Each axis keeps its
// window as a sorted row of cells tagged with their age; a transaction retires
// the oldest cell and inserts the new sample together, so one sample is taken
// every cycle while the output is not stalled, and its median appears on the
// output in the cycle after acceptance. A new sample is taken whenever the
// output register is empty or is being read in the same cycle. An even window
// gives the floor of the mean of the two middle values.
module three_axis_running_median (
  input  logic  clk_i,
  input  logic  rst_ni,
  tarm_sample_if.sink   sample_i,
  tarm_median_if.source median_o
);
  import tarm_pkg::*;

  logic out_valid_q, out_valid_d;
  logic accept;

  // handshake: the cells advance only when the output can take the result
  assign sample_i.ready = !out_valid_q || median_o.ready;
  assign accept         = sample_i.valid && sample_i.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept) begin
      out_valid_d = 1'b1;
    end else if (median_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign median_o.valid = out_valid_q;

  // one sorted cell row per axis
  tarm_chain u_chain_x (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (accept),
    .sample_i   (sample_i.sample_x),
    .median_o   (median_o.median_x)
  );

  tarm_chain u_chain_y (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (accept),
    .sample_i   (sample_i.sample_y),
    .median_o   (median_o.median_y)
  );

  tarm_chain u_chain_z (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .shift_en_i (accept),
    .sample_i   (sample_i.sample_z),
    .median_o   (median_o.median_z)
  );

endmodule

/* design/tarm_cell.sv */
module tarm_cell (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 shift_en_i,
  input  tarm_pkg::sample_t    sample_i,
  input  tarm_pkg::age_t       idx_i,
  input  tarm_pkg::cell_link_t lo_i,
  input  tarm_pkg::cell_link_t hi_i,
  input  logic                 rm_below_i,
  output tarm_pkg::cell_link_t link_o,
  output logic                 rm_o
);
  import tarm_pkg::*;

  sample_t value_q, value_d;
  age_t    age_q, age_d;
  logic    own_le;
  logic    rm_at;
  logic    del;
  cell_link_t own;
  cell_link_t c_cur;
  cell_link_t c_prev;

  // compare with the incoming sample
  assign own_le = (value_q <= sample_i);
  assign own    = '{value: value_q, age: age_q, le: own_le};
  assign link_o = own;

  // the oldest entry leaves the window
  assign del   = (age_q == MaxAge);
  assign rm_at = rm_below_i | del;
  assign rm_o  = rm_at;

  // compacted view after removal: slot i and slot i-1
  assign c_cur  = rm_at      ? hi_i : own;
  assign c_prev = rm_below_i ? own  : lo_i;

  // insert the new sample in sorted place
  always_comb begin
    priority if (c_cur.le) begin
      value_d = c_cur.value;
      age_d   = c_cur.age + age_t'(1);
    end else if (c_prev.le) begin
      value_d = sample_i;
      age_d   = '0;
    end else begin
      value_d = c_prev.value;
      age_d   = c_prev.age + age_t'(1);
    end
  end

  // cell storage, zeros with distinct ages after reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
      age_q   <= idx_i;
    end else if (shift_en_i) begin
      value_q <= value_d;
      age_q   <= age_d;
    end
  end

endmodule

/* design/tarm_chain.sv */
module tarm_chain (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              shift_en_i,
  input  tarm_pkg::sample_t sample_i,
  output tarm_pkg::sample_t median_o
);
  import tarm_pkg::*;

  cell_link_t links [WindowLength];
  cell_link_t lo    [WindowLength];
  cell_link_t hi    [WindowLength];
  logic       rm    [WindowLength+1];

  assign rm[0] = 1'b0;

  // sorted row of cells, smallest value in cell 0
  for (genvar i = 0; i < WindowLength; i++) begin : g_cell
    if (i == 0) begin : g_lo_edge
      assign lo[i] = '{value: '0, age: '0, le: 1'b1};
    end else begin : g_lo
      assign lo[i] = links[i-1];
    end
    if (i == WindowLength - 1) begin : g_hi_edge
      assign hi[i] = '{value: '0, age: '0, le: 1'b0};
    end else begin : g_hi
      assign hi[i] = links[i+1];
    end

    tarm_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_en_i (shift_en_i),
      .sample_i   (sample_i),
      .idx_i      (age_t'(i)),
      .lo_i       (lo[i]),
      .hi_i       (hi[i]),
      .rm_below_i (rm[i]),
      .link_o     (links[i]),
      .rm_o       (rm[i+1])
    );
  end

  // median taken from the middle of the sorted row
  if (EvenWindow) begin : g_even
    logic signed [DataW:0] mid_sum;
    assign mid_sum  = {links[MidIdx-1].value[DataW-1], links[MidIdx-1].value}
                    + {links[MidIdx].value[DataW-1], links[MidIdx].value};
    assign median_o = mid_sum[DataW:1];
  end else begin : g_odd
    assign median_o = links[MidIdx].value;
  end

endmodule

/* design/tarm_checker.sv */
`include "three_axis_running_median_defines.svh"

module tarm_checker (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              in_valid_i,
  input logic              in_ready_i,
  input logic              out_valid_i,
  input logic              out_ready_i,
  input tarm_pkg::sample_t median_x_i,
  input tarm_pkg::sample_t median_y_i,
  input tarm_pkg::sample_t median_z_i
);
  import tarm_pkg::*;

  // every accepted sample produces a result in the next cycle
  `TARM_ASSERT_NEXT(a_result_follows, in_valid_i && in_ready_i, out_valid_i)

  // no new sample while a result is stalled
  `TARM_ASSERT_NOW(a_no_accept_on_stall, out_valid_i && !out_ready_i, !in_ready_i)

  // a stalled result stays offered
  `TARM_ASSERT_NEXT(a_valid_holds, out_valid_i && !out_ready_i, out_valid_i)

  // a stalled result keeps its value
  `TARM_ASSERT_NEXT(a_data_holds, out_valid_i && !out_ready_i,
                    $stable(median_x_i) && $stable(median_y_i) && $stable(median_z_i))

endmodule

bind three_axis_running_median tarm_checker u_tarm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (sample_i.valid),
  .in_ready_i  (sample_i.ready),
  .out_valid_i (median_o.valid),
  .out_ready_i (median_o.ready),
  .median_x_i  (median_o.median_x),
  .median_y_i  (median_o.median_y),
  .median_z_i  (median_o.median_z)
);
